FILE: hw/rtl/ladrc_pkg.sv
// shared types, constants and saturation helper for the linear adrc controller
// no dependencies
package ladrc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned WIDE_W = 48;
    localparam int unsigned OPND_W = 50;
    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [2:0] REG_OBS_BW        = 3'd1;
    localparam logic [2:0] REG_CTL_BW        = 3'd2;
    localparam logic [2:0] REG_PLANT_GAIN    = 3'd3;
    localparam logic [2:0] REG_DRIVE_MIN     = 3'd4;
    localparam logic [2:0] REG_DRIVE_MAX     = 3'd5;

    localparam logic [31:0] RST_SAMPLE_PERIOD = 32'd4294967;
    localparam logic [30:0] RST_OBS_BW        = 31'd0;
    localparam logic [30:0] RST_CTL_BW        = 31'd0;
    localparam logic [31:0] RST_PLANT_GAIN    = 32'h0001_0000;
    localparam logic [31:0] RST_DRIVE_MIN     = 32'h8000_0000;
    localparam logic [31:0] RST_DRIVE_MAX     = 32'h7FFF_FFFF;

    localparam logic signed [OPND_W-1:0] S48_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [OPND_W-1:0] S48_MIN = -50'sh0_8000_0000_0000;

    typedef struct packed {
        logic signed [WORD_W-1:0] measured;
        logic signed [WORD_W-1:0] setpoint;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] drive;
        logic                     clamped;
    } t_out_item;

    function automatic logic signed [WIDE_W-1:0] sat48(input logic signed [OPND_W-1:0] v);
        logic signed [WIDE_W-1:0] r;
        if (v > S48_MAX) begin
            r = S48_MAX[WIDE_W-1:0];
        end else if (v < S48_MIN) begin
            r = S48_MIN[WIDE_W-1:0];
        end else begin
            r = v[WIDE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [OPND_W-1:0] ext48(input logic signed [WIDE_W-1:0] v);
        return {{(OPND_W-WIDE_W){v[WIDE_W-1]}}, v};
    endfunction

endpackage

FILE: hw/rtl/ladrc_mul.sv
// shared multiplier: 48 by 48 bit magnitude product in three 48x16 steps,
// shift right by 16 or 32 with truncation toward zero, saturate to 48 bits
// depends on ladrc_pkg
module ladrc_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [ladrc_pkg::OPND_W-1:0]    i_a,
    input  logic signed [ladrc_pkg::OPND_W-1:0]    i_b,
    input  logic                                   i_sh32,
    output logic                                   o_done,
    output logic signed [ladrc_pkg::WIDE_W-1:0]    o_res
);

    logic [ladrc_pkg::OPND_W-1:0] w_ua;
    logic [ladrc_pkg::OPND_W-1:0] w_ub;
    logic [ladrc_pkg::OPND_W-1:0] w_abs_a;
    logic [ladrc_pkg::OPND_W-1:0] w_abs_b;
    logic [47:0] r_ma;
    logic [47:0] r_mb;
    logic        r_neg;
    logic        r_sh32;
    logic [1:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [95:0] r_acc;
    logic [63:0] w_prod;
    logic [95:0] w_shr;
    logic        w_big;

    assign w_ua    = i_a;
    assign w_ub    = i_b;
    assign w_abs_a = w_ua[ladrc_pkg::OPND_W-1] ? (~w_ua + 50'd1) : w_ua;
    assign w_abs_b = w_ub[ladrc_pkg::OPND_W-1] ? (~w_ub + 50'd1) : w_ub;
    assign w_prod  = r_ma * r_mb[47:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma   <= w_abs_a[47:0];
            r_mb   <= w_abs_b[47:0];
            r_neg  <= i_a[ladrc_pkg::OPND_W-1] ^ i_b[ladrc_pkg::OPND_W-1];
            r_sh32 <= i_sh32;
            r_acc  <= 96'd0;
        end else if (r_busy) begin
            r_acc <= {r_acc[79:0], 16'd0} + {32'd0, w_prod};
            r_mb  <= {r_mb[31:0], 16'd0};
        end
    end

    assign w_shr = r_sh32 ? {32'd0, r_acc[95:32]} : {16'd0, r_acc[95:16]};
    assign w_big = |w_shr[95:48];

    always_comb begin
        if (!r_neg) begin
            o_res = (w_big || w_shr[47]) ? 48'sh7FFF_FFFF_FFFF : w_shr[47:0];
        end else begin
            o_res = (w_big || (w_shr[47] && (|w_shr[46:0]))) ? 48'sh8000_0000_0000
                                                               : (~w_shr[47:0] + 48'd1);
        end
    end

    assign o_done = r_done;

endmodule

FILE: hw/rtl/ladrc_div.sv
// restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit divisor
// no dependencies
module ladrc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quo
);

    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_dsr;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_trial = {r_rem, r_quo[63]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'd0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: hw/rtl/linear_adrc_eso_controller_core.sv
// linear adrc controller top level: config registers, observer state, sequencer
// depends on ladrc_pkg, ladrc_mul, ladrc_div
//
// One transaction (measured, setpoint) yields one transaction (drive, clamped).
// The observer update and control law run as twelve products on one shared
// 48x16 multiplier, followed by a divider load state and a bit-serial divide
// by plant_gain. The divide is skipped when plant_gain is zero, and a result
// waits for the output register while i_out_stall holds the item in it.
// o_in_stall is high from acceptance until the result is placed in the output
// register. Write the registers only while idle.
module linear_adrc_eso_controller_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  ladrc_pkg::t_in_item                   i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output ladrc_pkg::t_out_item                  o_out_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ladrc_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ISSUE = 3'd1;
    localparam logic [2:0] PH_WAIT  = 3'd2;
    localparam logic [2:0] PH_DIV   = 3'd3;
    localparam logic [2:0] PH_OUT   = 3'd4;
    localparam logic [2:0] PH_DSET  = 3'd5;

    localparam logic [3:0] ST_WO2   = 4'd0;
    localparam logic [3:0] ST_BETA3 = 4'd1;
    localparam logic [3:0] ST_T1    = 4'd2;
    localparam logic [3:0] ST_T2A   = 4'd3;
    localparam logic [3:0] ST_T2B   = 4'd4;
    localparam logic [3:0] ST_T3    = 4'd5;
    localparam logic [3:0] ST_Z1    = 4'd6;
    localparam logic [3:0] ST_Z2    = 4'd7;
    localparam logic [3:0] ST_Z3    = 4'd8;
    localparam logic [3:0] ST_WC2   = 4'd9;
    localparam logic [3:0] ST_P     = 4'd10;
    localparam logic [3:0] ST_NUM   = 4'd11;

    logic [31:0]        r_ts;
    logic [30:0]        r_wo;
    logic [30:0]        r_wc;
    logic signed [31:0] r_b0;
    logic signed [31:0] r_umin;
    logic signed [31:0] r_umax;

    logic signed [47:0] r_z1;
    logic signed [47:0] r_z2;
    logic signed [47:0] r_z3;
    logic signed [31:0] r_last;

    logic [2:0]         r_phase;
    logic [3:0]         r_step;
    logic signed [31:0] r_ref;
    logic signed [47:0] r_eps;
    logic signed [47:0] r_wo2;
    logic signed [47:0] r_beta3;
    logic signed [47:0] r_t1;
    logic signed [47:0] r_t2;
    logic signed [47:0] r_t3;
    logic signed [47:0] r_wc2;
    logic signed [47:0] r_p;
    logic signed [47:0] r_num;
    logic               r_qneg;
    logic               r_out_valid;
    ladrc_pkg::t_out_item r_out;
    ladrc_pkg::t_out_item r_res;

    logic               w_in_acc;
    logic               w_cfg_wr;
    logic [2:0]         w_idx;
    logic               w_mul_start;
    logic signed [49:0] w_ma;
    logic signed [49:0] w_mb;
    logic               w_sh32;
    logic               w_mul_done;
    logic signed [47:0] w_mres;
    logic               w_div_start;
    logic [63:0]        w_dividend;
    logic [31:0]        w_divisor;
    logic               w_div_done;
    logic [63:0]        w_quo;
    logic [47:0]        w_num_u;
    logic [47:0]        w_num_mag;
    logic [31:0]        w_b0_u;
    logic signed [64:0] w_q;
    logic signed [64:0] w_umax;
    logic signed [64:0] w_umin;
    logic signed [64:0] w_v1;
    logic signed [64:0] w_v2;
    logic signed [49:0] w_wo;
    logic signed [49:0] w_wc;
    logic signed [49:0] w_beta1;
    logic signed [49:0] w_beta2;
    logic signed [47:0] w_u0;

    assign pready   = 1'b1;
    assign w_idx    = paddr[4:2];
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts   <= ladrc_pkg::RST_SAMPLE_PERIOD;
            r_wo   <= ladrc_pkg::RST_OBS_BW;
            r_wc   <= ladrc_pkg::RST_CTL_BW;
            r_b0   <= ladrc_pkg::RST_PLANT_GAIN;
            r_umin <= ladrc_pkg::RST_DRIVE_MIN;
            r_umax <= ladrc_pkg::RST_DRIVE_MAX;
        end else if (w_cfg_wr) begin
            case (w_idx)
                ladrc_pkg::REG_SAMPLE_PERIOD: r_ts   <= pwdata;
                ladrc_pkg::REG_OBS_BW:        r_wo   <= pwdata[30:0];
                ladrc_pkg::REG_CTL_BW:        r_wc   <= pwdata[30:0];
                ladrc_pkg::REG_PLANT_GAIN:    r_b0   <= pwdata;
                ladrc_pkg::REG_DRIVE_MIN:     r_umin <= pwdata;
                ladrc_pkg::REG_DRIVE_MAX:     r_umax <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ladrc_pkg::REG_SAMPLE_PERIOD: prdata = r_ts;
            ladrc_pkg::REG_OBS_BW:        prdata = {1'b0, r_wo};
            ladrc_pkg::REG_CTL_BW:        prdata = {1'b0, r_wc};
            ladrc_pkg::REG_PLANT_GAIN:    prdata = r_b0;
            ladrc_pkg::REG_DRIVE_MIN:     prdata = r_umin;
            ladrc_pkg::REG_DRIVE_MAX:     prdata = r_umax;
            default:                      prdata = 32'd0;
        endcase
    end

    // operand selection for the shared multiplier
    assign w_wo    = {19'd0, r_wo};
    assign w_wc    = {19'd0, r_wc};
    assign w_beta1 = w_wo + w_wo + w_wo;
    assign w_beta2 = ladrc_pkg::ext48(ladrc_pkg::sat48(ladrc_pkg::ext48(r_wo2)
                     + ladrc_pkg::ext48(r_wo2) + ladrc_pkg::ext48(r_wo2)));

    always_comb begin
        w_ma  = w_wo;
        w_mb  = w_wo;
        w_sh32 = 1'b0;
        case (r_step)
            ST_WO2: begin
                w_ma = w_wo;
                w_mb = w_wo;
            end
            ST_BETA3: begin
                w_ma = ladrc_pkg::ext48(r_wo2);
                w_mb = w_wo;
            end
            ST_T1: begin
                w_ma = w_beta1;
                w_mb = ladrc_pkg::ext48(r_eps);
            end
            ST_T2A: begin
                w_ma = w_beta2;
                w_mb = ladrc_pkg::ext48(r_eps);
            end
            ST_T2B: begin
                w_ma = {{18{r_b0[31]}}, r_b0};
                w_mb = {{18{r_last[31]}}, r_last};
            end
            ST_T3: begin
                w_ma = ladrc_pkg::ext48(r_beta3);
                w_mb = ladrc_pkg::ext48(r_eps);
            end
            ST_Z1: begin
                w_ma   = ladrc_pkg::ext48(r_t1);
                w_mb   = {18'd0, r_ts};
                w_sh32 = 1'b1;
            end
            ST_Z2: begin
                w_ma   = ladrc_pkg::ext48(r_t2);
                w_mb   = {18'd0, r_ts};
                w_sh32 = 1'b1;
            end
            ST_Z3: begin
                w_ma   = ladrc_pkg::ext48(r_t3);
                w_mb   = {18'd0, r_ts};
                w_sh32 = 1'b1;
            end
            ST_WC2: begin
                w_ma = w_wc;
                w_mb = w_wc;
            end
            ST_P: begin
                w_ma = ladrc_pkg::ext48(r_wc2);
                w_mb = ladrc_pkg::ext48(ladrc_pkg::sat48({{18{r_ref[31]}}, r_ref}
                       - ladrc_pkg::ext48(r_z1)));
            end
            ST_NUM: begin
                w_ma = w_wc + w_wc;
                w_mb = ladrc_pkg::ext48(r_z2);
            end
            default: ;
        endcase
    end

    assign w_mul_start = (r_phase == PH_ISSUE);

    ladrc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .i_sh32  (w_sh32),
        .o_done  (w_mul_done),
        .o_res   (w_mres)
    );

    assign w_num_u   = r_num;
    assign w_num_mag = w_num_u[47] ? (~w_num_u + 48'd1) : w_num_u;
    assign w_b0_u    = r_b0;
    assign w_divisor = w_b0_u[31] ? (~w_b0_u + 32'd1) : w_b0_u;
    assign w_dividend = {w_num_mag, 16'd0};

    ladrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    assign w_u0 = ladrc_pkg::sat48(ladrc_pkg::ext48(r_p) - ladrc_pkg::ext48(w_mres));

    // sign, clamp and flag
    assign w_q    = r_qneg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
    assign w_umax = {{33{r_umax[31]}}, r_umax};
    assign w_umin = {{33{r_umin[31]}}, r_umin};
    assign w_v1   = (w_q > w_umax) ? w_umax : w_q;
    assign w_v2   = (w_v1 < w_umin) ? w_umin : w_v1;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_div_start = (r_phase == PH_DSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_step      <= ST_WO2;
            r_out_valid <= 1'b0;
            r_z1        <= 48'sd0;
            r_z2        <= 48'sd0;
            r_z3        <= 48'sd0;
            r_last      <= 32'sd0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_phase != PH_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_phase)
                PH_IDLE: begin
                    if (w_in_acc) begin
                        r_step  <= ST_WO2;
                        r_phase <= PH_ISSUE;
                    end
                end
                PH_ISSUE: begin
                    r_phase <= PH_WAIT;
                end
                PH_WAIT: begin
                    if (w_mul_done) begin
                        case (r_step)
                            ST_Z1: r_z1 <= ladrc_pkg::sat48(ladrc_pkg::ext48(r_z1)
                                           + ladrc_pkg::ext48(w_mres));
                            ST_Z2: r_z2 <= ladrc_pkg::sat48(ladrc_pkg::ext48(r_z2)
                                           + ladrc_pkg::ext48(w_mres));
                            ST_Z3: r_z3 <= ladrc_pkg::sat48(ladrc_pkg::ext48(r_z3)
                                           + ladrc_pkg::ext48(w_mres));
                            default: ;
                        endcase
                        if (r_step == ST_NUM) begin
                            r_phase <= (r_b0 == 32'sd0) ? PH_OUT : PH_DSET;
                        end else begin
                            r_step  <= r_step + 4'd1;
                            r_phase <= PH_ISSUE;
                        end
                    end
                end
                PH_DSET: begin
                    r_phase <= PH_DIV;
                end
                PH_DIV: begin
                    if (w_div_done) begin
                        r_last  <= w_v2[31:0];
                        r_phase <= PH_OUT;
                    end
                end
                PH_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_phase     <= PH_IDLE;
                    end
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ref <= i_in_data.setpoint;
            r_eps <= ladrc_pkg::sat48({{18{i_in_data.measured[31]}}, i_in_data.measured}
                     - ladrc_pkg::ext48(r_z1));
        end
        if (r_phase == PH_WAIT && w_mul_done) begin
            case (r_step)
                ST_WO2:   r_wo2   <= w_mres;
                ST_BETA3: r_beta3 <= w_mres;
                ST_T1:    r_t1    <= ladrc_pkg::sat48(ladrc_pkg::ext48(r_z2)
                                     + ladrc_pkg::ext48(w_mres));
                ST_T2A:   r_t2    <= w_mres;
                ST_T2B:   r_t2    <= ladrc_pkg::sat48(ladrc_pkg::ext48(r_z3)
                                     + ladrc_pkg::ext48(r_t2) + ladrc_pkg::ext48(w_mres));
                ST_T3:    r_t3    <= w_mres;
                ST_WC2:   r_wc2   <= w_mres;
                ST_P:     r_p     <= w_mres;
                ST_NUM: begin
                    r_num <= ladrc_pkg::sat48(ladrc_pkg::ext48(w_u0)
                             - ladrc_pkg::ext48(r_z3));
                    r_res.drive   <= r_last;
                    r_res.clamped <= 1'b1;
                end
                default: ;
            endcase
        end
        if (w_div_start) begin
            r_qneg <= r_num[47] ^ r_b0[31];
        end
        if (r_phase == PH_DIV && w_div_done) begin
            r_res.drive   <= w_v2[31:0];
            r_res.clamped <= (w_v2 != w_q);
        end
        if (r_phase == PH_OUT && (!r_out_valid || !i_out_stall)) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = (r_phase != PH_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: tb/sv/linear_adrc_eso_controller_core_tb.sv
// self-checking testbench for linear_adrc_eso_controller_core
// depends on ladrc_pkg and the controller rtl; holds its own observer and control-law predictor
module linear_adrc_eso_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CFG = 8;
    localparam int ITEMS_PER_CFG = 217;
    localparam int TAIL_CYCLES = 160;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam longint W48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint W48_MIN = -64'sh0000_8000_0000_0000;

    typedef enum int {IDLE_SRC_LIGHT, IDLE_SINK_LIGHT, IDLE_NONE} t_idle_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    ladrc_pkg::t_in_item    i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    ladrc_pkg::t_out_item   o_out_data;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ladrc_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    linear_adrc_eso_controller_core uut (.*);

    always #2 i_clk = ~i_clk;

    // shadow configuration and observer state
    bit [31:0]          cfg_ts;
    bit [30:0]          cfg_wo;
    bit [30:0]          cfg_wc;
    logic signed [31:0] cfg_b0;
    logic signed [31:0] cfg_umin;
    logic signed [31:0] cfg_umax;
    longint             z_pos, z_vel, z_dist, prev_drive;

    ladrc_pkg::t_in_item  sample_q[$];
    ladrc_pkg::t_out_item drive_expect_q[$];
    t_idle_mode           idle_mode = IDLE_SRC_LIGHT;
    int                   errors = 0;
    int                   quiet_cycles = 0;

    function automatic longint clip48(longint v);
        if (v > W48_MAX) return W48_MAX;
        if (v < W48_MIN) return W48_MIN;
        return v;
    endfunction

    function automatic bit [63:0] magnitude(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    // product shifted right by sh, magnitude truncated, saturated to 48 bits
    function automatic longint qmul(longint a, longint b, int sh);
        bit [127:0] ua, ub, p;
        longint     v;
        ua = {64'd0, magnitude(a)};
        ub = {64'd0, magnitude(b)};
        p = (ua * ub) >> sh;
        if (p > (128'd1 << 48)) p = 128'd1 << 48;
        v = longint'(p[63:0]);
        if ((a < 0) != (b < 0)) v = -v;
        return clip48(v);
    endfunction

    function automatic ladrc_pkg::t_out_item predict_drive(ladrc_pkg::t_in_item it);
        ladrc_pkg::t_out_item res;
        longint ts, wo, wc, b0, y, r, wo2, beta1, beta2, beta3, err;
        longint t1, t2, t3, wc2, u0, num, q, v;
        bit [63:0] qm;
        ts = longint'({32'd0, cfg_ts});
        wo = longint'({33'd0, cfg_wo});
        wc = longint'({33'd0, cfg_wc});
        b0 = longint'(cfg_b0);
        y = longint'(it.measured);
        r = longint'(it.setpoint);
        wo2 = qmul(wo, wo, 16);
        beta1 = clip48(3 * wo);
        beta2 = clip48(3 * wo2);
        beta3 = qmul(wo2, wo, 16);
        err = clip48(y - z_pos);
        t1 = clip48(z_vel + qmul(beta1, err, 16));
        t2 = clip48(z_dist + qmul(beta2, err, 16) + qmul(b0, prev_drive, 16));
        t3 = qmul(beta3, err, 16);
        z_pos = clip48(z_pos + qmul(t1, ts, 32));
        z_vel = clip48(z_vel + qmul(t2, ts, 32));
        z_dist = clip48(z_dist + qmul(t3, ts, 32));
        wc2 = qmul(wc, wc, 16);
        u0 = clip48(qmul(wc2, clip48(r - z_pos), 16) - qmul(2 * wc, z_vel, 16));
        num = clip48(u0 - z_dist);
        if (b0 == 0) begin
            res.drive = prev_drive[31:0];
            res.clamped = 1'b1;
        end else begin
            qm = (magnitude(num) << 16) / magnitude(b0);
            if ((num < 0) != (b0 < 0)) begin
                q = (qm >= 64'h8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000 : -longint'(qm);
            end else begin
                q = (qm > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF : longint'(qm);
            end
            v = (q > longint'(cfg_umax)) ? longint'(cfg_umax) : q;
            v = (v < longint'(cfg_umin)) ? longint'(cfg_umin) : v;
            res.drive = v[31:0];
            res.clamped = (v != q);
            prev_drive = v;
        end
        return res;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        bit idle;
        if (i_in_valid && !o_in_stall) begin
            drive_expect_q.push_back(predict_drive(i_in_data));
        end
        if (!i_in_valid || !o_in_stall) begin
            case (idle_mode)
                IDLE_SRC_LIGHT:  idle = ($urandom_range(99) < 8);
                IDLE_SINK_LIGHT: idle = ($urandom_range(99) < 83);
                default:         idle = 1'b0;
            endcase
            if (i_rst_n && sample_q.size() != 0 && !idle) begin
                i_in_data <= sample_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output monitor and watchdog
    always @(posedge i_clk) begin
        ladrc_pkg::t_out_item exp_item;
        if (o_out_valid && !i_out_stall) begin
            if (drive_expect_q.size() == 0) begin
                $display("%0t unexpected transaction drive=%h clamped=%b", $time,
                         o_out_data.drive, o_out_data.clamped);
                errors++;
            end else begin
                exp_item = drive_expect_q.pop_front();
                if (exp_item.drive !== o_out_data.drive) begin
                    $display("%0t drive mismatch expected %h actual %h", $time,
                             exp_item.drive, o_out_data.drive);
                    errors++;
                end
                if (exp_item.clamped !== o_out_data.clamped) begin
                    $display("%0t clamped mismatch expected %b actual %b", $time,
                             exp_item.clamped, o_out_data.clamped);
                    errors++;
                end
            end
        end
        case (idle_mode)
            IDLE_SRC_LIGHT:  i_out_stall <= ($urandom_range(99) < 83);
            IDLE_SINK_LIGHT: i_out_stall <= ($urandom_range(99) < 8);
            default:         i_out_stall <= 1'b0;
        endcase
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ladrc_pkg::REG_SAMPLE_PERIOD: cfg_ts = data;
            ladrc_pkg::REG_OBS_BW:        cfg_wo = data[30:0];
            ladrc_pkg::REG_CTL_BW:        cfg_wc = data[30:0];
            ladrc_pkg::REG_PLANT_GAIN:    cfg_b0 = data;
            ladrc_pkg::REG_DRIVE_MIN:     cfg_umin = data;
            ladrc_pkg::REG_DRIVE_MAX:     cfg_umax = data;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(64)) - 32);
            3: return $urandom();
            default: return 32'(int'($urandom_range(1 << 22)) - (1 << 21));
        endcase
    endfunction

    initial begin
        logic [31:0] cfg_tab [N_CFG][6];
        logic [31:0] corner [8];
        cfg_ts = ladrc_pkg::RST_SAMPLE_PERIOD;
        cfg_wo = ladrc_pkg::RST_OBS_BW;
        cfg_wc = ladrc_pkg::RST_CTL_BW;
        cfg_b0 = ladrc_pkg::RST_PLANT_GAIN;
        cfg_umin = ladrc_pkg::RST_DRIVE_MIN;
        cfg_umax = ladrc_pkg::RST_DRIVE_MAX;
        z_pos = 0;
        z_vel = 0;
        z_dist = 0;
        prev_drive = 0;
        cfg_tab[0] = '{32'd4294967, 32'd50 << 16, 32'd10 << 16, 32'h0001_0000,
                       -(32'd100 << 16), 32'd100 << 16};
        cfg_tab[1] = '{32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h8000_0000, 32'h7FFF_FFFF};
        cfg_tab[2] = '{32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        cfg_tab[3] = '{32'd42949673, 32'd20 << 16, 32'd5 << 16, -(32'd2 << 16),
                       32'd5 << 16, -(32'd5 << 16)};
        cfg_tab[4] = '{$urandom(), $urandom(), $urandom(), 32'd1, 32'hFFFF_FFFF, 32'd1};
        cfg_tab[5] = '{32'd429497, 32'd200 << 16, 32'd40 << 16, 32'd3 << 16,
                       -(32'd1000 << 16), 32'd1000 << 16};
        cfg_tab[6] = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom()};
        cfg_tab[7] = '{ladrc_pkg::RST_SAMPLE_PERIOD, 32'(ladrc_pkg::RST_OBS_BW),
                       32'(ladrc_pkg::RST_CTL_BW), ladrc_pkg::RST_PLANT_GAIN,
                       ladrc_pkg::RST_DRIVE_MIN, ladrc_pkg::RST_DRIVE_MAX};
        corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1,
                   32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < N_CFG; k++) begin
            idle_mode = (k < 3) ? IDLE_SRC_LIGHT : (k < 6) ? IDLE_SINK_LIGHT : IDLE_NONE;
            for (int i = 0; i < 6; i++) reg_write(3'(i), cfg_tab[k][i]);
            // write to an unmapped register index is ignored
            reg_write(3'd6, $urandom());
            reg_write(3'd7, $urandom());
            if (k == 0) begin
                for (int i = 0; i < 8; i++) begin
                    sample_q.push_back('{measured: corner[i], setpoint: corner[7 - i]});
                    sample_q.push_back('{measured: corner[i], setpoint: corner[i]});
                end
            end
            for (int n = 0; n < ITEMS_PER_CFG; n++) begin
                sample_q.push_back('{measured: pick_word(), setpoint: pick_word()});
            end
            while (sample_q.size() != 0 || i_in_valid || drive_expect_q.size() != 0)
                @(posedge i_clk);
            repeat (TAIL_CYCLES) @(posedge i_clk);
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
